/* hw/rtl/tst_pkg.sv */
package tst_pkg;

  // table size and slot index width
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  // opcodes of an input item
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD_PER  = 3'd1;
  localparam logic [2:0] OP_ADD_ONE  = 3'd2;
  localparam logic [2:0] OP_STOP     = 3'd3;
  localparam logic [2:0] OP_START    = 3'd4;
  localparam logic [2:0] OP_CHANGE   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // margin taken off the minimum for the sleep hint
  localparam logic [31:0] SLEEP_MARGIN = 32'd10;

  // shared subtractor result
  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
    logic        zero;
  } alu_res_t;

  // write port of the slot store
  typedef struct packed {
    logic             en_rem;
    logic             en_ival;
    logic [IDX_W-1:0] addr;
    logic [31:0]      rem;
    logic [31:0]      ival;
  } store_wr_t;

endpackage

/* hw/rtl/tst_alu.sv */
module tst_alu import tst_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_res_t    res
);

  logic [32:0] wide;

  // 33-bit subtract, top bit is the borrow
  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.diff   = wide[31:0];
  assign res.borrow = wide[32];
  assign res.zero   = (wide[31:0] == 32'd0);

endmodule

/* hw/rtl/tst_store.sv */
module tst_store import tst_pkg::*; (
  input  logic             clk,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_rem,
  output logic [31:0]      rd_ival
);

  logic [31:0] rem_mem  [SLOTS];
  logic [31:0] ival_mem [SLOTS];

  // one write port per array
  always_ff @(posedge clk) begin
    if (wr.en_rem) begin
      rem_mem[wr.addr] <= wr.rem;
    end
    if (wr.en_ival) begin
      ival_mem[wr.addr] <= wr.ival;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_rem  <= rem_mem[rd_addr];
    rd_ival <= ival_mem[rd_addr];
  end

endmodule

/* hw/rtl/periodic_and_oneshot_timer_slots_unit.sv */
// A command item, once accepted, goes to S_CMD, which loads its single result when the
// output register is free. A tick goes through S_ELAPSE, walks the slots in S_SCAN and
// loads its summary in S_SUMM: every slot is scanned once per pass, with one store read
// and one subtract-compare on the shared unit for each running slot of that pass.
// Throughput: one item at a time; the next is taken once the last result is loaded, and
// each result that finds the output register full adds its wait. Reset clears all slot flags
// and the previous timestamp; stored counts need no clearing.
module periodic_and_oneshot_timer_slots_unit import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] now_ms,
  input  logic        exclusive,
  input  logic [31:0] interval,
  input  logic [3:0]  slot,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  kind,
  output logic [3:0]  slot_index,
  output logic [31:0] min_remaining,
  output logic [31:0] sleep_ms,
  output logic        last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAPSE,
    S_SCAN,
    S_EVAL,
    S_SUMM,
    S_CMD
  } state_t;

  state_t           state;
  state_t           adv_state;

  logic [2:0]       op_q;
  logic [31:0]      now_q;
  logic             excl_q;
  logic [31:0]      ival_q;
  logic [3:0]       slot_q;

  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] periodic;
  logic [SLOTS-1:0] running;
  logic [31:0]      prev_time;
  logic [31:0]      elapsed;
  logic [31:0]      minr;
  logic             pass;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] adv_idx;
  logic             adv_pass;

  logic [31:0]      alu_a;
  logic [31:0]      alu_b;
  alu_res_t         alu;
  store_wr_t        wr;
  logic [31:0]      rd_rem;
  logic [31:0]      rd_ival;

  logic             res_free;
  logic             res_load;
  logic             eligible;
  logic             fire;
  logic             eval_go;
  logic [31:0]      cand;
  logic             cand_counts;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] slot_addr;
  logic             addr_ok;
  logic [31:0]      sleep_val;
  logic             is_add;
  logic             is_slot_op;

  assign cmd_ready = (state == S_IDLE);
  assign res_free  = !res_valid || res_ready;

  // shared subtract-compare unit
  tst_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // interval and remaining count store
  tst_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx),
    .rd_rem  (rd_rem),
    .rd_ival (rd_ival)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (state)
      S_ELAPSE: begin
        alu_a = now_q;
        alu_b = prev_time;
      end
      S_SUMM: begin
        alu_a = minr;
        alu_b = SLEEP_MARGIN;
      end
      default: begin
        alu_a = rd_rem;
        alu_b = elapsed;
      end
    endcase
  end

  // per-slot decisions during the walk
  assign eligible    = used[idx] && running[idx] && (periodic[idx] == !pass);
  assign fire        = alu.borrow || alu.zero;
  assign eval_go     = !fire || res_free;
  assign cand        = fire ? rd_ival : alu.diff;
  assign cand_counts = !(pass && fire);

  // a result is loaded this cycle
  assign res_load = (state == S_EVAL) ? (eval_go && fire) :
                    (((state == S_SUMM) || (state == S_CMD)) && res_free);

  // next slot of the walk
  always_comb begin
    if (idx == IDX_W'(SLOTS - 1)) begin
      adv_idx   = '0;
      adv_pass  = 1'b1;
      adv_state = pass ? S_SUMM : S_SCAN;
    end else begin
      adv_idx   = idx + 1'b1;
      adv_pass  = pass;
      adv_state = S_SCAN;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // target slot check
  assign slot_addr  = slot_q[IDX_W-1:0];
  assign addr_ok    = (32'(slot_q) < SLOTS) && used[slot_addr];
  assign is_add     = (op_q == OP_ADD_PER) || (op_q == OP_ADD_ONE);
  assign is_slot_op = (op_q == OP_STOP) || (op_q == OP_START) || (op_q == OP_CHANGE);

  // sleep hint from minimum minus margin
  assign sleep_val = (excl_q && (|used) && !alu.borrow && !alu.zero) ? alu.diff : 32'd0;

  // store writes
  always_comb begin
    wr.en_rem  = 1'b0;
    wr.en_ival = 1'b0;
    wr.addr    = idx;
    wr.rem     = cand;
    wr.ival    = ival_q;
    if (state == S_EVAL) begin
      wr.en_rem = eval_go && cand_counts;
    end else if (state == S_CMD && res_free) begin
      if (is_add && free_found) begin
        wr.en_rem  = 1'b1;
        wr.en_ival = 1'b1;
        wr.addr    = free_idx;
        wr.rem     = ival_q;
      end else if (op_q == OP_CHANGE && addr_ok) begin
        wr.en_ival = 1'b1;
        wr.addr    = slot_addr;
      end
    end
  end

  // sequencer, slot flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      periodic  <= '0;
      running   <= '0;
      prev_time <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_q   <= opcode;
            now_q  <= now_ms;
            excl_q <= exclusive;
            ival_q <= interval;
            slot_q <= slot;
            state  <= (opcode == OP_TICK) ? S_ELAPSE : S_CMD;
          end
        end
        S_ELAPSE: begin
          elapsed   <= alu.diff;
          prev_time <= now_q;
          minr      <= '1;
          pass      <= 1'b0;
          idx       <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (eligible) begin
            state <= S_EVAL;
          end else begin
            idx   <= adv_idx;
            pass  <= adv_pass;
            state <= adv_state;
          end
        end
        S_EVAL: begin
          if (eval_go) begin
            if (fire) begin
              kind          <= KIND_FIRED;
              slot_index    <= 4'(idx);
              min_remaining <= '0;
              sleep_ms      <= '0;
              last          <= 1'b0;
              if (pass) begin
                used[idx]    <= 1'b0;
                running[idx] <= 1'b0;
              end
            end
            if (cand_counts && cand < minr) begin
              minr <= cand;
            end
            idx   <= adv_idx;
            pass  <= adv_pass;
            state <= adv_state;
          end
        end
        S_SUMM: begin
          if (res_free) begin
            kind          <= KIND_SUMMARY;
            slot_index    <= '0;
            min_remaining <= minr;
            sleep_ms      <= sleep_val;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_CMD: begin
          if (res_free) begin
            min_remaining <= '0;
            sleep_ms      <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
            if (is_add) begin
              if (free_found) begin
                used[free_idx]     <= 1'b1;
                periodic[free_idx] <= (op_q == OP_ADD_PER);
                running[free_idx]  <= 1'b1;
                kind               <= KIND_DONE;
                slot_index         <= 4'(free_idx);
              end else begin
                kind       <= KIND_ERROR;
                slot_index <= '0;
              end
            end else if (is_slot_op && addr_ok) begin
              if (op_q == OP_STOP) begin
                running[slot_addr] <= 1'b0;
              end else if (op_q == OP_START) begin
                running[slot_addr] <= 1'b1;
              end
              kind       <= KIND_DONE;
              slot_index <= slot_q;
            end else begin
              kind       <= KIND_ERROR;
              slot_index <= slot_q;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a running slot is always in use
  a_running_used: assert property (@(posedge clk) disable iff (rst)
    (running & ~used) == '0)
    else $error("running flag set on a free slot");

  // a new item only finds the final result of the previous one pending
  a_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && res_valid) |-> last)
    else $error("item accepted while earlier results are pending");

  // a fired one-shot slot is freed
  a_oneshot_freed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && fire && pass && eval_go) |=> !used[$past(idx)])
    else $error("fired one-shot slot still in use");

  // fire results never close an item
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_FIRED) |-> !last)
    else $error("fire result marked last");

endmodule
